// File: design/paged_stack_node_accounting_unit_macros.svh
// ----------------------------------------------------------------------------
// Paged stack node accounting unit: assertion macros
// Shared macros for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef PAGED_STACK_NODE_ACCOUNTING_UNIT_MACROS_SVH
`define PAGED_STACK_NODE_ACCOUNTING_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSNA_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("paged stack check failed");

// The consequent must hold in the cycle after the antecedent.
`define PSNA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("paged stack check failed");

`endif

// File: design/psna_pkg.sv
// ----------------------------------------------------------------------------
// Paged stack node accounting unit: package
// Operation and status codes, controller states and the control bundles.
// ----------------------------------------------------------------------------
package psna_pkg;

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int FIELD_W  = 11;
  localparam int DATA_W   = 32;
  localparam int OUT_W    = 72;

  localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

  localparam logic [FIELD_W-1:0] CAP_RESET = 11'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } psna_state_t;

  typedef struct packed {
    logic exec;
    logic read;
    logic load;
  } psna_cmd_t;

  typedef struct packed {
    logic slot_free;
  } psna_stat_t;

endpackage

// File: design/paged_stack_node_accounting_unit.sv
// ----------------------------------------------------------------------------
// Paged stack node accounting unit
// LIFO stack of values kept in pages, with page allocate and free accounting.
// ----------------------------------------------------------------------------
// Each item is a push, a pop or a clear and yields exactly one result. An item
// passes through accept, read and load in order: the accept step updates the
// counters and writes the value memory, the read step reads the new top entry
// through the single registered memory read port, and the load step loads the
// output register. The load waits while an earlier result is still held there,
// so a stalled output delays that item. The page capacity may be written only
// while no item is in progress; a capacity of zero behaves as one.
// ----------------------------------------------------------------------------
module paged_stack_node_accounting_unit
  import psna_pkg::*;
#(
  parameter int STACK_DEPTH = 1024,
  parameter int VALUE_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // push_value
  input  logic [DATA_W-1:0]    in_tdata,
  // kind
  input  logic [KIND_W-1:0]    in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // top_value, top_valid, stack_size, page_count, page_allocated, pages_freed
  output logic [OUT_W-1:0]     out_tdata,
  // status
  output logic [STATUS_W-1:0]  out_tuser,
  input  logic                 cfg_we,
  input  logic [FIELD_W-1:0]   cfg_wdata
);

  psna_cmd_t  cmd;
  psna_stat_t stat;

  psna_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  psna_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_kind    (in_tuser),
    .in_value   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: design/psna_ctrl.sv
// ----------------------------------------------------------------------------
// Paged stack node accounting unit: controller
// Sequences accept, top-of-stack read and result load for each item.
// ----------------------------------------------------------------------------
module psna_ctrl
  import psna_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  psna_stat_t  stat,
  output psna_cmd_t   cmd
);

  psna_state_t state_r;
  psna_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.exec  = in_tvalid;
      end
      ST_READ: begin
        cmd.read = 1'b1;
      end
      ST_LOAD: begin
        cmd.load = stat.slot_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// File: design/psna_datapath.sv
// ----------------------------------------------------------------------------
// Paged stack node accounting unit: datapath
// Value memory, size and page counters, page fill tracking and result register.
// ----------------------------------------------------------------------------
module psna_datapath
  import psna_pkg::*;
#(
  parameter int STACK_DEPTH = 1024,
  parameter int VALUE_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  psna_cmd_t            cmd,
  output psna_stat_t           stat,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [DATA_W-1:0]    in_value,
  input  logic                 cfg_we,
  input  logic [FIELD_W-1:0]   cfg_wdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,
  output logic [STATUS_W-1:0]  out_tuser
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [VALUE_BITS-1:0] mem [STACK_DEPTH];
  logic [VALUE_BITS-1:0] rd_data_r;

  logic [FIELD_W-1:0]  cap_r;
  logic [FIELD_W-1:0]  cap;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       pg_r, pg_nxt, pg_tmp;
  logic [FIELD_W-1:0]  up_r, up_nxt;
  logic [FIELD_W-1:0]  lo_r, lo_nxt;
  logic [FIELD_W-1:0]  back;
  logic [STATUS_W-1:0] st_nxt, st_r;
  logic                alloc_nxt, alloc_r;
  logic [CW-1:0]       freed_nxt, freed_r;
  logic                we;
  logic [63:0]         in_wide;
  logic [63:0]         rd_wide;
  logic [31:0]         cnt_ext, pg_ext, freed_ext;

  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;
  logic [STATUS_W-1:0] out_user_r;

  assign cap     = (cap_r == '0) ? FIELD_W'(1) : cap_r;
  assign back    = (pg_r == CW'(1)) ? lo_r : up_r;
  assign in_wide = 64'(in_value);

  always_comb begin
    cnt_nxt   = cnt_r;
    pg_nxt    = pg_r;
    pg_tmp    = pg_r;
    up_nxt    = up_r;
    lo_nxt    = lo_r;
    st_nxt    = STATUS_OK;
    alloc_nxt = 1'b0;
    freed_nxt = '0;
    we        = 1'b0;
    case (in_kind)
      KIND_PUSH: begin
        if (cnt_r >= CW'(STACK_DEPTH)) begin
          st_nxt = STATUS_PUSH_FULL;
        end else begin
          we = 1'b1;
          if (pg_r == '0) begin
            pg_nxt    = CW'(1);
            lo_nxt    = '0;
            up_nxt    = '0;
            alloc_nxt = 1'b1;
          end else if (back >= cap) begin
            if (pg_r >= CW'(2)) begin
              lo_nxt = up_r;
            end
            up_nxt    = '0;
            pg_nxt    = pg_r + CW'(1);
            alloc_nxt = 1'b1;
          end
          if (lo_nxt < cap || pg_nxt == CW'(1)) begin
            lo_nxt = lo_nxt + FIELD_W'(1);
          end else begin
            up_nxt = up_nxt + FIELD_W'(1);
          end
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      KIND_POP: begin
        if (cnt_r == '0) begin
          st_nxt = STATUS_POP_EMPTY;
        end else if (pg_r > CW'(1) && up_r != '0) begin
          up_nxt  = up_r - FIELD_W'(1);
          cnt_nxt = cnt_r - CW'(1);
        end else begin
          cnt_nxt = cnt_r - CW'(1);
          if (lo_r != '0) begin
            lo_nxt = lo_r - FIELD_W'(1);
          end
          if (lo_nxt == '0) begin
            if (pg_r > CW'(1)) begin
              freed_nxt = CW'(1);
              pg_tmp    = pg_r - CW'(1);
            end
            if (pg_tmp > CW'(1)) begin
              pg_nxt = pg_tmp;
              up_nxt = '0;
              lo_nxt = (32'(cnt_nxt) < 32'(cap)) ? FIELD_W'(cnt_nxt) : cap;
            end else begin
              if (pg_tmp == CW'(1)) begin
                freed_nxt = freed_nxt + CW'(1);
              end
              pg_nxt = '0;
              lo_nxt = '0;
              up_nxt = '0;
            end
          end
        end
      end
      KIND_CLEAR: begin
        freed_nxt = pg_r;
        pg_nxt    = '0;
        cnt_nxt   = '0;
        lo_nxt    = '0;
        up_nxt    = '0;
      end
      default: begin
        st_nxt = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
      cnt_r <= '0;
      pg_r  <= '0;
      up_r  <= '0;
      lo_r  <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (cmd.exec) begin
        cnt_r <= cnt_nxt;
        pg_r  <= pg_nxt;
        up_r  <= up_nxt;
        lo_r  <= lo_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      st_r    <= st_nxt;
      alloc_r <= alloc_nxt;
      freed_r <= freed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && we) begin
      mem[cnt_r[AW-1:0]] <= in_wide[VALUE_BITS-1:0];
    end
    if (cmd.read) begin
      rd_data_r <= mem[cnt_r[AW-1:0] - AW'(1)];
    end
  end

  assign rd_wide   = 64'(rd_data_r);
  assign cnt_ext   = 32'(cnt_r);
  assign pg_ext    = 32'(pg_r);
  assign freed_ext = 32'(freed_r);

  assign stat.slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_user_r <= st_r;
      out_data_r <= {5'd0,
                     freed_ext[FIELD_W-1:0],
                     alloc_r,
                     pg_ext[FIELD_W-1:0],
                     cnt_ext[FIELD_W-1:0],
                     (cnt_r != '0),
                     (cnt_r != '0) ? rd_wide[DATA_W-1:0] : {DATA_W{1'b0}}};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// File: design/psna_checker.sv
// ----------------------------------------------------------------------------
// Paged stack node accounting unit: port checker
// Concurrent checks on the ports of the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "paged_stack_node_accounting_unit_macros.svh"

module psna_checker
  import psna_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [OUT_W-1:0]     out_tdata,
  input logic [STATUS_W-1:0]  out_tuser
);

  `PSNA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `PSNA_ASSERT_NEXT(a_one_item_at_a_time, in_tvalid && in_tready, !in_tready)
  `PSNA_ASSERT_SAME(a_pop_empty_is_empty, out_tvalid && out_tuser == STATUS_POP_EMPTY, !out_tdata[32])
  `PSNA_ASSERT_SAME(a_alloc_on_good_push, out_tvalid && out_tdata[55], out_tdata[32] && out_tuser == STATUS_OK)

endmodule

bind paged_stack_node_accounting_unit psna_checker u_psna_checker (.*);
